// File: hdl/assert_macros.svh
// Assertion macros shared by the cache RTL.
// No dependencies; checks clock on i_clk and are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LKVC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LKVC_ASSERT(lbl, prop, msg)
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/lkvc_pkg.sv
// Shared constants, types and control structs for the LRU key/value cache.
// No dependencies.
`default_nettype none
package lkvc_pkg;
    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CAP_W     = 5;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_SET = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic scan_start;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
    } t_dp_stat;
endpackage
`default_nettype wire

// File: hdl/lkvc_dp.sv
// Datapath: slot key/value memories, rank and valid registers, scan compare,
// commit logic and result register. Depends on lkvc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lkvc_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire lkvc_pkg::t_dp_cmd       i_cmd,
    output lkvc_pkg::t_dp_stat           o_stat,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [lkvc_pkg::CAP_W-1:0]    i_cfg_data,
    input  wire [0:0]                    i_op,
    input  wire [lkvc_pkg::KEY_W-1:0]    i_key,
    input  wire [lkvc_pkg::VAL_W-1:0]    i_wval,
    output logic                         o_hit,
    output logic [lkvc_pkg::VAL_W-1:0]   o_rval
);
    import lkvc_pkg::*;

    // slot storage
    logic [KEY_W-1:0] mem_key [ENTRIES];
    logic [VAL_W-1:0] mem_val [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]   r_rank [ENTRIES];
    logic [CNT_W-1:0]   r_fill;
    logic [CAP_W-1:0]   r_cap;

    // item being worked on
    t_cmd             r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_wval;

    // scan
    logic [CNT_W-1:0] r_idx;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;
    logic [KEY_W-1:0] r_key_q;
    logic [VAL_W-1:0] r_val_q;

    logic             r_found, r_free, r_lru_any;
    logic [IDX_W-1:0] r_found_idx, r_found_rank, r_free_idx, r_lru_idx;
    logic [VAL_W-1:0] r_found_val;

    logic [VAL_W-1:0] r_out_val;
    logic             r_out_hit;

    logic             cmp_valid, cmp_match, cmp_free, cmp_lru;
    logic [IDX_W-1:0] cmp_rank;
    logic [CNT_W-1:0] fill_m1;
    logic [IDX_W-1:0] lru_rank;
    logic [CMP_W-1:0] cap_ext, cap_eff;
    logic             have_room, is_set, ins_free, evict, do_promote, do_write;
    logic [IDX_W-1:0] tgt, limit;
    logic             rd_en;

    assign o_cfg_ready = 1'b1;

    assign fill_m1  = r_fill - CNT_W'(1);
    assign lru_rank = fill_m1[IDX_W-1:0];

    assign cmp_valid = r_valid[r_cmp_idx];
    assign cmp_rank  = r_rank[r_cmp_idx];
    assign cmp_match = r_cmp_vld && cmp_valid && (r_key_q == r_key);
    assign cmp_free  = r_cmp_vld && !cmp_valid;
    assign cmp_lru   = r_cmp_vld && cmp_valid && (cmp_rank == lru_rank);

    assign rd_en = i_cmd.scan_step && (r_idx < CNT_W'(ENTRIES));
    assign o_stat.scan_done = (r_idx == CNT_W'(ENTRIES)) && !r_cmp_vld;

    // capacity clamp: zero acts as one, beyond the slot count acts as full
    always_comb begin
        cap_ext = CMP_W'(r_cap);
        cap_eff = cap_ext;
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign have_room  = CMP_W'(r_fill) < cap_eff;
    assign is_set     = (r_op == CMD_SET);
    assign ins_free   = !r_found && is_set && have_room && r_free;
    assign evict      = !r_found && is_set && !ins_free && r_lru_any;
    assign do_promote = r_found || ins_free || evict;
    assign do_write   = is_set && do_promote;
    assign tgt   = r_found ? r_found_idx : (ins_free ? r_free_idx : r_lru_idx);
    assign limit = r_found ? r_found_rank : lru_rank;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_fill    <= '0;
            r_cap     <= CAP_RESET;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_free    <= 1'b0;
            r_lru_any <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.scan_start) begin
                r_idx     <= '0;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
                r_free    <= 1'b0;
                r_lru_any <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= rd_en;
                if (rd_en) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (cmp_match) begin
                    r_found <= 1'b1;
                end
                if (cmp_free) begin
                    r_free <= 1'b1;
                end
                if (cmp_lru) begin
                    r_lru_any <= 1'b1;
                end
            end
            if (i_cmd.commit && ins_free) begin
                r_valid[tgt] <= 1'b1;
                r_fill       <= r_fill + CNT_W'(1);
            end
        end
    end

    // item latch, scan captures, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_op   <= t_cmd'(i_op);
            r_key  <= i_key;
            r_wval <= i_wval;
        end
        if (i_cmd.scan_step) begin
            r_cmp_idx <= r_idx[IDX_W-1:0];
            if (cmp_match && !r_found) begin
                r_found_idx  <= r_cmp_idx;
                r_found_rank <= cmp_rank;
                r_found_val  <= r_val_q;
            end
            if (cmp_free && !r_free) begin
                r_free_idx <= r_cmp_idx;
            end
            if (cmp_lru) begin
                r_lru_idx <= r_cmp_idx;
            end
        end
        if (i_cmd.commit) begin
            r_out_hit <= r_found;
            r_out_val <= (r_found && !is_set) ? r_found_val : MISS_VALUE;
        end
    end

    // recency ranks: the promoted slot goes to 0, younger entries age by one
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_promote) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (IDX_W'(i) == tgt) begin
                    r_rank[i] <= '0;
                end else if (r_valid[i] && (ins_free || r_rank[i] < limit)) begin
                    r_rank[i] <= r_rank[i] + IDX_W'(1);
                end
            end
        end
    end

    // key and value memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && do_write) begin
            mem_key[tgt] <= r_key;
            mem_val[tgt] <= r_wval;
        end
        if (rd_en) begin
            r_key_q <= mem_key[r_idx[IDX_W-1:0]];
            r_val_q <= mem_val[r_idx[IDX_W-1:0]];
        end
    end

    assign o_hit  = r_out_hit;
    assign o_rval = r_out_val;

    `LKVC_ASSERT(a_fill_matches_valid, $countones(r_valid) == int'(r_fill), "fill count out of step")
    `LKVC_ASSERT(a_fill_bound, r_fill <= CNT_W'(ENTRIES), "fill count beyond slot count")
    `LKVC_ASSERT(a_no_dup_key, !(i_cmd.scan_step && r_found && cmp_match), "key stored twice")
    `LKVC_ASSERT_NEXT(a_insert_grows, i_cmd.commit && ins_free, r_fill == $past(r_fill) + CNT_W'(1), "insert did not grow fill")
endmodule
`default_nettype wire

// File: hdl/lkvc_ctrl.sv
// Controller: sequences accept, slot scan and commit; owns the result valid flag.
// Depends on lkvc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lkvc_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output lkvc_pkg::t_dp_cmd   o_cmd,
    input  wire lkvc_pkg::t_dp_stat i_stat
);
    import lkvc_pkg::*;

    t_state r_state, n_state;
    logic   r_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // result register must be free or draining this cycle
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_tvalid;

    `LKVC_ASSERT(a_result_from_commit, $rose(r_m_tvalid) |-> $past(r_state == ST_UPDATE), "result without commit")
    `LKVC_ASSERT_NEXT(a_accept_scans, i_s_tvalid && o_s_tready, r_state == ST_SCAN, "accept did not start scan")
    `LKVC_ASSERT_NEXT(a_no_overwrite, r_state == ST_UPDATE && r_m_tvalid && !i_m_tready, r_state == ST_UPDATE && r_m_tvalid, "pending result overwritten")
endmodule
`default_nettype wire

// File: hdl/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_dp.
`default_nettype none
// Fully associative key/value cache of lkvc_pkg::ENTRIES slots with least-
// recently-used replacement. Each input transaction is a get (tuser 0) or a set
// (tuser 1) on a 32-bit key; each produces exactly one output transaction
// carrying the hit flag and, for a get hit, the stored value (all ones on a
// get miss and on any set). A hit, get or set, makes the entry the most recent.
// A set miss fills the lowest free slot while fewer entries than the configured
// capacity are held, otherwise it replaces the least recent entry. Capacity is
// written on the cfg channel (0 acts as 1, above the slot count acts as full);
// lowering it drops nothing, later set misses simply evict instead of filling.
// Write it only while no transaction is in flight. The store starts empty and
// needs no clearing pass after reset. One item is handled at a time: it is
// accepted, the slots are scanned through the single registered read port of
// the key and value memories, and the result is committed. The next item is
// accepted while the previous result still waits in the output register; a
// commit waits only while that register is full and is not being drained.
module lru_key_value_cache (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // configuration: capacity
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [lkvc_pkg::CAP_W-1:0] i_cfg_data,
    // input stream
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0] i_s_tdata, // [31:0] key, [63:32] write_value
    input  wire [0:0]            i_s_tuser,   // [0] command
    // output stream
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output logic [lkvc_pkg::VAL_W-1:0] o_m_tdata, // [31:0] read_value
    output logic [0:0]           o_m_tuser    // [0] hit
);
    import lkvc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     hit;

    lkvc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    lkvc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_s_tuser),
        .i_key       (i_s_tdata[KEY_W-1:0]),
        .i_wval      (i_s_tdata[KEY_W+VAL_W-1:KEY_W]),
        .o_hit       (hit),
        .o_rval      (o_m_tdata)
    );

    assign o_m_tuser = hit;
endmodule
`default_nettype wire

// File: tb/sv/lkvc_reply_checker.sv
// Reply checker for the LRU key/value cache: watches the cfg, input and output channels.
// Depends on lkvc_pkg; keeps its own copy of the store and compares replies in order.
module lkvc_reply_checker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    input  wire                   i_cfg_ready,
    input  wire [lkvc_pkg::CAP_W-1:0] i_cfg_data,
    input  wire                   i_s_tvalid,
    input  wire                   i_s_tready,
    input  wire [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0] i_s_tdata, // [31:0] key, [63:32] write_value
    input  wire [0:0]             i_s_tuser,   // [0] command
    input  wire                   i_m_tvalid,
    input  wire                   i_m_tready,
    input  wire [lkvc_pkg::VAL_W-1:0] i_m_tdata, // [31:0] read_value
    input  wire [0:0]             i_m_tuser,   // [0] hit
    output int                    o_outstanding,
    output int                    o_failures
);
    import lkvc_pkg::*;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } t_reply;

    logic             slot_live [ENTRIES];
    logic [KEY_W-1:0] slot_tag  [ENTRIES];
    logic [VAL_W-1:0] slot_data [ENTRIES];
    logic [IDX_W-1:0] slot_age  [ENTRIES];   // 0 = most recent
    logic [CNT_W-1:0] live_count;
    logic [CAP_W-1:0] capacity;

    t_reply awaited_replies [$];
    int     failures = 0;
    int     reported = 0;

    function automatic void clear_store();
        for (int i = 0; i < ENTRIES; i++) begin
            slot_live[i] = 1'b0;
        end
        live_count = '0;
        capacity   = CAP_RESET;
    endfunction

    // Entry s becomes newest; live entries younger than limit age by one.
    function automatic void make_newest(int s, int limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_live[i] && i != s && int'(slot_age[i]) < limit)
                slot_age[i] = slot_age[i] + 1'b1;
        end
        slot_age[s] = '0;
    endfunction

    function automatic t_reply apply_command(t_cmd cmd, logic [KEY_W-1:0] key,
                                             logic [VAL_W-1:0] wval);
        t_reply r;
        int     eff_cap;
        int     found;
        int     slot;
        r.hit   = 1'b0;
        r.value = MISS_VALUE;
        eff_cap = (capacity == 0) ? 1 : ((int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity));
        found   = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && slot_live[i] && slot_tag[i] == key)
                found = i;
        end
        if (found >= 0) begin
            r.hit = 1'b1;
            if (cmd == CMD_GET)
                r.value = slot_data[found];
            else
                slot_data[found] = wval;
            make_newest(found, int'(slot_age[found]));
        end else if (cmd == CMD_SET) begin
            slot = -1;
            if (int'(live_count) < eff_cap) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && !slot_live[i])
                        slot = i;
                end
            end
            if (slot >= 0) begin
                slot_live[slot] = 1'b1;
                slot_tag[slot]  = key;
                slot_data[slot] = wval;
                make_newest(slot, ENTRIES);
                live_count = live_count + 1'b1;
            end else begin
                // full at the current capacity: reuse the oldest slot
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_live[i] && (slot < 0 || slot_age[i] > slot_age[slot]))
                        slot = i;
                end
                if (slot >= 0) begin
                    slot_tag[slot]  = key;
                    slot_data[slot] = wval;
                    make_newest(slot, int'(slot_age[slot]));
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            clear_store();
            awaited_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_data;
            // replies first: a reply never belongs to a request taken on the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_replies.size() == 0) begin
                    failures++;
                    if (reported < 10)
                        $display("unexpected reply: hit %0b value %h", i_m_tuser[0], i_m_tdata);
                    reported++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (want.hit !== i_m_tuser[0]) begin
                        failures++;
                        if (reported < 10)
                            $display("hit mismatch: expected %0b actual %0b",
                                     want.hit, i_m_tuser[0]);
                        reported++;
                    end
                    if (want.value !== i_m_tdata) begin
                        failures++;
                        if (reported < 10)
                            $display("read_value mismatch: expected %h actual %h",
                                     want.value, i_m_tdata);
                        reported++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_replies.push_back(apply_command(t_cmd'(i_s_tuser[0]),
                                                        i_s_tdata[KEY_W-1:0],
                                                        i_s_tdata[KEY_W+VAL_W-1:KEY_W]));
        end
        o_outstanding <= awaited_replies.size();
        o_failures    <= failures;
    end

endmodule

// File: tb/sv/tb_lru_key_value_cache.sv
// Testbench top for lru_key_value_cache: clock, reset, stimulus and verdict.
// Depends on lkvc_pkg, the cache RTL and lkvc_reply_checker.
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 143;
    localparam int LONG_HOLD     = 300;  // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES  = 40;   // extra idle cycles after the final settle
    localparam int POOL_SIZE     = 32;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CAP_W-1:0]       i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic [KEY_W+VAL_W-1:0] i_s_tdata   = '0;
    logic [0:0]             i_s_tuser   = '0;
    logic                   i_m_tready  = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [VAL_W-1:0]       o_m_tdata;
    logic [0:0]             o_m_tuser;

    int outstanding;
    int failures;

    // Shared between stimulus and receiver; written with NBAs by the stimulus only.
    logic quiet_mode        = 1'b0;
    int   hold_off_requests = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always #2 i_clk = ~i_clk;

    lru_key_value_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    lkvc_reply_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .o_outstanding (outstanding),
        .o_failures    (failures)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int draw_idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // One request transaction. Called at a rising edge; returns at the edge that
    // took the request, leaving tvalid high so back-to-back items need no toggle.
    task automatic send_request(t_cmd cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval);
        int gap;
        gap = quiet_mode ? 0 : draw_idle_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {wval, key};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
    endtask

    // Stop offering and wait until every reply has come back; the block is then idle,
    // since each request yields exactly one reply.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] cap);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    // Fresh key pool per phase; the extreme keys always sit in the first slots.
    task automatic refill_key_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
    endtask

    // Keys drawn from a window a little wider than the capacity give a mix of
    // hits, fills and evictions; a tenth are wholly random and almost always miss.
    task automatic run_random_phase(int items, int span);
        int               r;
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wval;
        for (int n = 0; n < items; n++) begin
            r    = $urandom_range(0, 99);
            key  = (r < 10) ? $urandom : key_pool[$urandom_range(0, span)];
            cmd  = t_cmd'($urandom_range(0, 1));
            r    = $urandom_range(0, 99);
            wval = (r < 4) ? 32'h8000_0000 : (r < 8) ? 32'h7FFF_FFFF : $urandom;
            send_request(cmd, key, wval);
        end
    endtask

    // Receiver: random back-pressure after each reply, plus the long hold-off
    // the stimulus asks for, counted here cycle by cycle.
    initial begin : receiver
        int stall_left;
        int served;
        stall_left = 0;
        served     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_requests != served) begin
                served     = hold_off_requests;
                stall_left = LONG_HOLD;
            end else if (o_m_tvalid && i_m_tready) begin
                stall_left = quiet_mode ? 0 : draw_idle_gap();
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned phase_caps [PHASE_COUNT];
        int          eff_cap;
        phase_caps = '{16, 3, 1, 31, 0, 7, 17, 12, 2, 0};
        phase_caps[PHASE_COUNT-1] = $urandom_range(0, 31);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset capacity: empty-store miss, extreme keys and
        // values, set on a present key, and a get carrying a stray write value.
        send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_GET, 32'h8000_0000, 32'hA5A5_A5A5);
        send_request(CMD_SET, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(CMD_SET, 32'h7FFF_FFFF, 32'h1234_5678);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(CMD_GET, 32'h5555_5555, 32'h0000_0000);

        // Capacity lowered below the four held entries: set misses now evict.
        write_capacity(CAP_W'(2));
        send_request(CMD_SET, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_SET, 32'h0000_0001, 32'h0000_0001);
        send_request(CMD_GET, 32'hAAAA_AAAA, 32'h0000_0000);
        send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);

        // Random phases across capacities: reset value, minimum, zero, above the
        // slot count, all ones, and a drop from a full store to a few entries.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_capacity(CAP_W'(phase_caps[p]));
            quiet_mode <= (p == 3 || p == 7);
            if (p == 0 || p == 5)
                hold_off_requests <= hold_off_requests + 1;
            eff_cap = (phase_caps[p] == 0) ? 1 :
                      (phase_caps[p] > ENTRIES) ? ENTRIES : int'(phase_caps[p]);
            refill_key_pool();
            run_random_phase(PHASE_ITEMS, eff_cap + $urandom_range(1, 6));
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/lkvc_pkg.sv
hdl/lkvc_dp.sv
hdl/lkvc_ctrl.sv
hdl/lru_key_value_cache.sv
tb/sv/lkvc_reply_checker.sv
tb/sv/tb_lru_key_value_cache.sv
